// ===== src/dtpm_pkg.sv =====
// Package for the DNS transaction problem monitor.
// It holds the table size, protocol constants, problem codes and shared types.
// It depends on nothing else.
package dtpm_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [15:0] QUERY_PORT = 16'd53;
   localparam logic [15:0] MIN_RESPONSE_LEN = 16'd12;
   localparam logic [7:0] RETRY_MAX = 8'hFF;
   localparam int TC_BIT = 1;

   localparam logic [3:0] RCODE_SERVFAIL = 4'd2;
   localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;
   localparam logic [3:0] RCODE_REFUSED = 4'd5;

   typedef enum logic [2:0] {
      KIND_SLOW = 3'd0,
      KIND_NXDOMAIN = 3'd1,
      KIND_SERVFAIL = 3'd2,
      KIND_REFUSED = 3'd3,
      KIND_TRUNCATED = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic is_resp;
      logic [47:0] key;
      logic [63:0] time_ns;
      logic [15:0] qtype;
      logic [31:0] server;
      logic v6;
      logic tc;
      logic [3:0] rcode;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic [47:0] key;
   } tag_type;

   typedef struct packed {
      logic [63:0] start;
      logic [15:0] qtype;
      logic [31:0] server;
      logic v6;
      logic [7:0] retries;
   } entry_type;

endpackage

// ===== src/dtpm_front.sv =====
// Front end of the DNS transaction problem monitor.
// It accepts transactions, drops those that cannot change the table, and builds commands.
// It depends on dtpm_pkg.
module dtpm_front (
   input logic enable,
   input logic queue_full,
   input logic req_valid,
   output logic req_ready,
   input logic req_type,
   input logic [47:0] req_flow_key,
   input logic [63:0] req_time_ns,
   input logic [15:0] req_dst_port,
   input logic [15:0] req_query_type,
   input logic [31:0] req_server_addr,
   input logic req_server_is_v6,
   input logic [15:0] req_response_len,
   input logic [7:0] req_response_flags_byte,
   input logic [7:0] req_response_rcode_byte,
   output logic push,
   output dtpm_pkg::cmd_type cmd
);

   logic keep;

   assign req_ready = enable && !queue_full;
   assign keep = req_type ? (req_response_len >= dtpm_pkg::MIN_RESPONSE_LEN)
                          : (req_dst_port == dtpm_pkg::QUERY_PORT);
   assign push = req_valid && req_ready && keep;

   always_comb begin
      cmd.is_resp = req_type;
      cmd.key = req_flow_key;
      cmd.time_ns = req_time_ns;
      cmd.qtype = req_query_type;
      cmd.server = req_server_is_v6 ? 32'd0 : req_server_addr;
      cmd.v6 = req_server_is_v6;
      cmd.tc = req_response_flags_byte[dtpm_pkg::TC_BIT];
      cmd.rcode = req_response_rcode_byte[3:0];
   end

endmodule

// ===== src/dtpm_queue.sv =====
// Two-entry command queue between the front end and the table engine.
// It depends on dtpm_pkg.
module dtpm_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input dtpm_pkg::cmd_type push_cmd,
   input logic pop,
   output logic full,
   output logic not_empty,
   output dtpm_pkg::cmd_type head
);

   dtpm_pkg::cmd_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/dtpm_back.sv =====
// Table engine of the DNS transaction problem monitor.
// It scans the pending-query table, updates it and registers problem events.
// It depends on dtpm_pkg.
module dtpm_back (
   input logic clock,
   input logic reset,
   input logic [63:0] threshold,
   input logic cmd_valid,
   input dtpm_pkg::cmd_type cmd,
   output logic pop,
   output logic clearing,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [2:0] rsp_problem_kind,
   output logic [63:0] rsp_event_time,
   output logic [63:0] rsp_delay_ns,
   output logic [47:0] rsp_event_flow,
   output logic [15:0] rsp_event_query_type,
   output logic [31:0] rsp_event_server,
   output logic rsp_event_server_v6,
   output logic [7:0] rsp_retries,
   output logic [3:0] rsp_rcode
);

   localparam logic [dtpm_pkg::IDX_W-1:0] LAST_IDX =
      dtpm_pkg::IDX_W'(dtpm_pkg::TABLE_ENTRIES - 1);

   dtpm_pkg::tag_type tag_mem [dtpm_pkg::TABLE_ENTRIES];
   dtpm_pkg::entry_type ent_mem [dtpm_pkg::TABLE_ENTRIES];

   dtpm_pkg::state_type state_ff, state_in;
   dtpm_pkg::cmd_type cmd_ff, cmd_in;
   logic [dtpm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rd_vld_ff, rd_vld_in;
   logic [dtpm_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic have_free_ff, have_free_in;
   logic [dtpm_pkg::IDX_W-1:0] free_idx_ff, free_idx_in;
   dtpm_pkg::tag_type tag_q_ff;
   dtpm_pkg::entry_type ent_q_ff;
   logic out_valid_ff, out_valid_in;
   dtpm_pkg::kind_type kind_ff;
   logic [63:0] time_ff, lat_ff;
   dtpm_pkg::cmd_type ocmd_ff;
   dtpm_pkg::entry_type oent_ff;

   logic start, issue, hit, empty, last, done, problem;
   logic [dtpm_pkg::IDX_W-1:0] rd_addr;
   logic tag_we, ent_we, out_load;
   logic [dtpm_pkg::IDX_W-1:0] tag_waddr, ent_waddr;
   dtpm_pkg::tag_type tag_wdata;
   dtpm_pkg::entry_type ent_wdata;
   logic [63:0] latency;
   dtpm_pkg::kind_type kind;
   logic [7:0] next_retries;

   assign start = (state_ff == dtpm_pkg::ST_IDLE) && cmd_valid && !out_valid_ff;
   assign pop = start;
   assign clearing = (state_ff == dtpm_pkg::ST_CLEAR);
   assign issue = (state_ff == dtpm_pkg::ST_SCAN) &&
                  (cnt_ff < dtpm_pkg::CNT_W'(dtpm_pkg::TABLE_ENTRIES));
   assign rd_addr = cnt_ff[dtpm_pkg::IDX_W-1:0];
   assign hit = rd_vld_ff && tag_q_ff.valid && (tag_q_ff.key == cmd_ff.key);
   assign empty = rd_vld_ff && !tag_q_ff.valid;
   assign last = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign done = hit || last;
   assign latency = cmd_ff.time_ns - ent_q_ff.start;
   assign next_retries = (ent_q_ff.retries == dtpm_pkg::RETRY_MAX) ?
                         ent_q_ff.retries : ent_q_ff.retries + 8'd1;

   always_comb begin
      problem = 1'b1;
      if (cmd_ff.tc) begin
         kind = dtpm_pkg::KIND_TRUNCATED;
      end else if (cmd_ff.rcode == dtpm_pkg::RCODE_NXDOMAIN) begin
         kind = dtpm_pkg::KIND_NXDOMAIN;
      end else if (cmd_ff.rcode == dtpm_pkg::RCODE_SERVFAIL) begin
         kind = dtpm_pkg::KIND_SERVFAIL;
      end else if (cmd_ff.rcode == dtpm_pkg::RCODE_REFUSED) begin
         kind = dtpm_pkg::KIND_REFUSED;
      end else begin
         kind = dtpm_pkg::KIND_SLOW;
         problem = (latency > threshold);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtpm_pkg::ST_CLEAR: begin
            if (cnt_ff[dtpm_pkg::IDX_W-1:0] == LAST_IDX) begin
               state_in = dtpm_pkg::ST_IDLE;
            end
         end
         dtpm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = dtpm_pkg::ST_SCAN;
            end
         end
         dtpm_pkg::ST_SCAN: begin
            if (done) begin
               state_in = dtpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      tag_we = 1'b0;
      tag_waddr = rd_idx_ff;
      tag_wdata = '0;
      ent_we = 1'b0;
      ent_waddr = rd_idx_ff;
      ent_wdata = ent_q_ff;
      out_load = 1'b0;
      case (state_ff)
         dtpm_pkg::ST_CLEAR: begin
            tag_we = 1'b1;
            tag_waddr = cnt_ff[dtpm_pkg::IDX_W-1:0];
         end
         dtpm_pkg::ST_SCAN: begin
            if (hit && !cmd_ff.is_resp) begin
               ent_we = 1'b1;
               ent_wdata.start = cmd_ff.time_ns;
               ent_wdata.server = cmd_ff.server;
               ent_wdata.v6 = cmd_ff.v6;
               ent_wdata.retries = next_retries;
            end else if (hit) begin
               tag_we = 1'b1;
               out_load = problem;
            end else if (last && !cmd_ff.is_resp && (have_free_ff || empty)) begin
               tag_we = 1'b1;
               tag_waddr = have_free_ff ? free_idx_ff : rd_idx_ff;
               tag_wdata.valid = 1'b1;
               tag_wdata.key = cmd_ff.key;
               ent_we = 1'b1;
               ent_waddr = tag_waddr;
               ent_wdata.start = cmd_ff.time_ns;
               ent_wdata.qtype = cmd_ff.qtype;
               ent_wdata.server = cmd_ff.server;
               ent_wdata.v6 = cmd_ff.v6;
               ent_wdata.retries = 8'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd_in = start ? cmd : cmd_ff;
      cnt_in = cnt_ff;
      if (clearing || issue) begin
         cnt_in = cnt_ff + dtpm_pkg::CNT_W'(1);
      end else if (start) begin
         cnt_in = '0;
      end
      rd_vld_in = issue;
      rd_idx_in = rd_addr;
      have_free_in = have_free_ff;
      free_idx_in = free_idx_ff;
      if (start) begin
         have_free_in = 1'b0;
      end else if (empty && !have_free_ff) begin
         have_free_in = 1'b1;
         free_idx_in = rd_idx_ff;
      end
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtpm_pkg::ST_CLEAR;
         cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         have_free_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         have_free_ff <= have_free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rd_idx_ff <= rd_idx_in;
      free_idx_ff <= free_idx_in;
      if (out_load) begin
         kind_ff <= kind;
         time_ff <= cmd_ff.time_ns;
         lat_ff <= latency;
         ocmd_ff <= cmd_ff;
         oent_ff <= ent_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_q_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_q_ff <= ent_mem[rd_addr];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_problem_kind = kind_ff;
   assign rsp_event_time = time_ff;
   assign rsp_delay_ns = lat_ff;
   assign rsp_event_flow = ocmd_ff.key;
   assign rsp_event_query_type = oent_ff.qtype;
   assign rsp_event_server = oent_ff.server;
   assign rsp_event_server_v6 = oent_ff.v6;
   assign rsp_retries = oent_ff.retries;
   assign rsp_rcode = ocmd_ff.rcode;

endmodule

// ===== src/dns_transaction_problem_monitor_core.sv =====
// Top level of the DNS transaction problem monitor.
// It joins the front end, the command queue and the table engine.
// It depends on dtpm_pkg, dtpm_front, dtpm_queue and dtpm_back.
//
// The req channel carries query-sent and response-received transactions; the rsp
// channel carries one problem event for a response that is slow, truncated or
// carries NXDOMAIN, SERVFAIL or REFUSED. The csr port writes the slow threshold.
// Queries not to port 53 and responses under 12 bytes are dropped on acceptance.
// Other transactions wait in a two-entry queue for the table engine, which
// scans the 1024-entry table one entry per cycle through registered memory reads.
// A transaction ends when the scan finds its key or reaches the last entry, and
// the engine takes the next transaction from the queue only after that.
// An event appears on rsp in the cycle after the scan finds its entry.
// After reset the engine clears every table entry, with req_ready low.
// When rsp is stalled, the queue keeps accepting until it holds two transactions,
// and the engine starts no new transaction until the pending event is taken.
module dns_transaction_problem_monitor_core (
   input logic clock,
   input logic reset,
   input logic csr_write_enable,
   input logic [63:0] csr_write_data,
   input logic req_valid,
   output logic req_ready,
   input logic req_type,
   input logic [47:0] req_flow_key,
   input logic [63:0] req_time_ns,
   input logic [15:0] req_dst_port,
   input logic [15:0] req_query_type,
   input logic [31:0] req_server_addr,
   input logic req_server_is_v6,
   input logic [15:0] req_response_len,
   input logic [7:0] req_response_flags_byte,
   input logic [7:0] req_response_rcode_byte,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [2:0] rsp_problem_kind,
   output logic [63:0] rsp_event_time,
   output logic [63:0] rsp_delay_ns,
   output logic [47:0] rsp_event_flow,
   output logic [15:0] rsp_event_query_type,
   output logic [31:0] rsp_event_server,
   output logic rsp_event_server_v6,
   output logic [7:0] rsp_retries,
   output logic [3:0] rsp_rcode
);

   logic [63:0] threshold_ff;
   logic push, pop, full, not_empty, clearing;
   dtpm_pkg::cmd_type push_cmd, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 64'd0;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   dtpm_front u_front (
      .enable(!clearing),
      .queue_full(full),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_flow_key(req_flow_key),
      .req_time_ns(req_time_ns),
      .req_dst_port(req_dst_port),
      .req_query_type(req_query_type),
      .req_server_addr(req_server_addr),
      .req_server_is_v6(req_server_is_v6),
      .req_response_len(req_response_len),
      .req_response_flags_byte(req_response_flags_byte),
      .req_response_rcode_byte(req_response_rcode_byte),
      .push(push),
      .cmd(push_cmd)
   );

   dtpm_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .full(full),
      .not_empty(not_empty),
      .head(head)
   );

   dtpm_back u_back (
      .clock(clock),
      .reset(reset),
      .threshold(threshold_ff),
      .cmd_valid(not_empty),
      .cmd(head),
      .pop(pop),
      .clearing(clearing),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_problem_kind(rsp_problem_kind),
      .rsp_event_time(rsp_event_time),
      .rsp_delay_ns(rsp_delay_ns),
      .rsp_event_flow(rsp_event_flow),
      .rsp_event_query_type(rsp_event_query_type),
      .rsp_event_server(rsp_event_server),
      .rsp_event_server_v6(rsp_event_server_v6),
      .rsp_retries(rsp_retries),
      .rsp_rcode(rsp_rcode)
   );

endmodule

// ===== src/dtpm_checker.sv =====
// Port-level checker for the DNS transaction problem monitor.
// It depends on dtpm_pkg and binds to dns_transaction_problem_monitor_core.
module dtpm_props (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_problem_kind,
   input logic [31:0] rsp_event_server,
   input logic rsp_event_server_v6,
   input logic [3:0] rsp_rcode
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Event pending right after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Stalled event dropped.");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_problem_kind == dtpm_pkg::KIND_SLOW) |->
      rsp_rcode != dtpm_pkg::RCODE_NXDOMAIN &&
      rsp_rcode != dtpm_pkg::RCODE_SERVFAIL &&
      rsp_rcode != dtpm_pkg::RCODE_REFUSED)
      else $error("Slow event carries an error rcode.");

   a_v6_server: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_server_v6 |-> rsp_event_server == 32'd0)
      else $error("IPv6 event carries an address.");

endmodule

bind dns_transaction_problem_monitor_core dtpm_props u_props (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_problem_kind(rsp_problem_kind),
   .rsp_event_server(rsp_event_server),
   .rsp_event_server_v6(rsp_event_server_v6),
   .rsp_rcode(rsp_rcode)
);

// ===== tb/dtpm_checker.sv =====
// Checker for the DNS transaction problem monitor: watches the req, rsp and csr ports,
// keeps its own pending-query table, predicts problem events and compares them in order.
// It depends on dtpm_pkg for the table size, protocol constants and problem codes.
module dtpm_checker (
   input logic clock,
   input logic reset,
   input logic csr_write_enable,
   input logic [63:0] csr_write_data,
   input logic req_valid,
   input logic req_ready,
   input logic req_type,
   input logic [47:0] req_flow_key,
   input logic [63:0] req_time_ns,
   input logic [15:0] req_dst_port,
   input logic [15:0] req_query_type,
   input logic [31:0] req_server_addr,
   input logic req_server_is_v6,
   input logic [15:0] req_response_len,
   input logic [7:0] req_response_flags_byte,
   input logic [7:0] req_response_rcode_byte,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_problem_kind,
   input logic [63:0] rsp_event_time,
   input logic [63:0] rsp_delay_ns,
   input logic [47:0] rsp_event_flow,
   input logic [15:0] rsp_event_query_type,
   input logic [31:0] rsp_event_server,
   input logic rsp_event_server_v6,
   input logic [7:0] rsp_retries,
   input logic [3:0] rsp_rcode,
   output int pending_events,
   output int fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      dtpm_pkg::kind_type kind;
      logic [63:0] event_time;
      logic [63:0] latency;
      logic [47:0] flow;
      logic [15:0] qtype;
      logic [31:0] server;
      logic v6;
      logic [7:0] retries;
      logic [3:0] rcode;
   } problem_event_type;

   problem_event_type expected_events[$];
   logic [63:0] thresh_ns;
   bit pend_valid[dtpm_pkg::TABLE_ENTRIES];
   logic [47:0] pend_key[dtpm_pkg::TABLE_ENTRIES];
   logic [63:0] pend_start[dtpm_pkg::TABLE_ENTRIES];
   logic [15:0] pend_qtype[dtpm_pkg::TABLE_ENTRIES];
   logic [31:0] pend_server[dtpm_pkg::TABLE_ENTRIES];
   logic pend_v6[dtpm_pkg::TABLE_ENTRIES];
   logic [7:0] pend_retries[dtpm_pkg::TABLE_ENTRIES];

   initial begin
      fail_count = 0;
      pending_events = 0;
      thresh_ns = '0;
      foreach (pend_valid[i]) pend_valid[i] = 1'b0;
   end

   function automatic int lookup_flow(logic [47:0] key);
      for (int i = 0; i < dtpm_pkg::TABLE_ENTRIES; i++)
         if (pend_valid[i] && pend_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < dtpm_pkg::TABLE_ENTRIES; i++)
         if (!pend_valid[i]) return i;
      return -1;
   endfunction

   task automatic track_transaction();
      int slot;
      logic [3:0] rcode;
      logic [63:0] latency;
      problem_event_type ev;
      bit problem;
      slot = lookup_flow(req_flow_key);
      rcode = req_response_rcode_byte[3:0];
      if (req_type == 1'b0) begin
         if (req_dst_port != dtpm_pkg::QUERY_PORT) return;
         if (slot >= 0) begin
            if (pend_retries[slot] < dtpm_pkg::RETRY_MAX) pend_retries[slot]++;
         end else begin
            slot = first_free();
            if (slot < 0) return;
            pend_valid[slot] = 1'b1;
            pend_key[slot] = req_flow_key;
            pend_qtype[slot] = req_query_type;
            pend_retries[slot] = '0;
         end
         pend_start[slot] = req_time_ns;
         pend_v6[slot] = req_server_is_v6;
         pend_server[slot] = req_server_is_v6 ? 32'd0 : req_server_addr;
         return;
      end
      if (req_response_len < dtpm_pkg::MIN_RESPONSE_LEN || slot < 0) return;
      latency = req_time_ns - pend_start[slot];
      problem = 1'b1;
      if (req_response_flags_byte[dtpm_pkg::TC_BIT]) ev.kind = dtpm_pkg::KIND_TRUNCATED;
      else if (rcode == dtpm_pkg::RCODE_NXDOMAIN) ev.kind = dtpm_pkg::KIND_NXDOMAIN;
      else if (rcode == dtpm_pkg::RCODE_SERVFAIL) ev.kind = dtpm_pkg::KIND_SERVFAIL;
      else if (rcode == dtpm_pkg::RCODE_REFUSED) ev.kind = dtpm_pkg::KIND_REFUSED;
      else if (latency > thresh_ns) ev.kind = dtpm_pkg::KIND_SLOW;
      else problem = 1'b0;
      pend_valid[slot] = 1'b0;
      if (!problem) return;
      ev.event_time = req_time_ns;
      ev.latency = latency;
      ev.flow = req_flow_key;
      ev.qtype = pend_qtype[slot];
      ev.server = pend_server[slot];
      ev.v6 = pend_v6[slot];
      ev.retries = pend_retries[slot];
      ev.rcode = rcode;
      expected_events.push_back(ev);
   endtask

   task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %h, actual %h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   task automatic check_event();
      problem_event_type ev;
      if (expected_events.size() == 0) begin
         $error("problem event with no transaction pending: flow %h", rsp_event_flow);
         fail_count++;
         return;
      end
      ev = expected_events.pop_front();
      compare_field("problem_kind", 64'(ev.kind), 64'(rsp_problem_kind));
      compare_field("event_time", ev.event_time, rsp_event_time);
      compare_field("delay_ns", ev.latency, rsp_delay_ns);
      compare_field("event_flow", 64'(ev.flow), 64'(rsp_event_flow));
      compare_field("event_query_type", 64'(ev.qtype), 64'(rsp_event_query_type));
      compare_field("event_server", 64'(ev.server), 64'(rsp_event_server));
      compare_field("event_server_v6", 64'(ev.v6), 64'(rsp_event_server_v6));
      compare_field("retries", 64'(ev.retries), 64'(rsp_retries));
      compare_field("rcode", 64'(ev.rcode), 64'(rsp_rcode));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) thresh_ns = csr_write_data;
         if (req_valid && req_ready) track_transaction();
         if (rsp_valid && rsp_ready) check_event();
      end
      pending_events = expected_events.size();
   end
endmodule

// ===== tb/tb.sv =====
// Top of the DNS transaction problem monitor testbench: clock, reset, stimulus and verdict.
// It depends on dtpm_pkg, dns_transaction_problem_monitor_core and dtpm_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 3200;
   localparam longint CYCLE_LIMIT = 40_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [47:0] req_flow_key = '0;
   logic [63:0] req_time_ns = '0;
   logic [15:0] req_dst_port = '0;
   logic [15:0] req_query_type = '0;
   logic [31:0] req_server_addr = '0;
   logic req_server_is_v6 = 1'b0;
   logic [15:0] req_response_len = '0;
   logic [7:0] req_response_flags_byte = '0;
   logic [7:0] req_response_rcode_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_problem_kind;
   logic [63:0] rsp_event_time;
   logic [63:0] rsp_delay_ns;
   logic [47:0] rsp_event_flow;
   logic [15:0] rsp_event_query_type;
   logic [31:0] rsp_event_server;
   logic rsp_event_server_v6;
   logic [7:0] rsp_retries;
   logic [3:0] rsp_rcode;
   int pending_events;
   int fail_count;

   int tx_idle_pct = 17;
   int rx_idle_pct = 88;
   longint cycle_count = 0;
   logic [63:0] clock_ns = '0;
   logic [47:0] flow_pool[8];

   dns_transaction_problem_monitor_core DUT (.*);
   dtpm_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send(logic rtype, logic [47:0] key, logic [63:0] t, logic [15:0] port,
                       logic [15:0] qtype, logic [31:0] srv, logic v6, logic [15:0] rlen,
                       logic [7:0] flags, logic [7:0] rcode);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rtype;
      req_flow_key <= key;
      req_time_ns <= t;
      req_dst_port <= port;
      req_query_type <= qtype;
      req_server_addr <= srv;
      req_server_is_v6 <= v6;
      req_response_len <= rlen;
      req_response_flags_byte <= flags;
      req_response_rcode_byte <= rcode;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_query(logic [47:0] key, logic [63:0] t, logic [15:0] port,
                             logic [15:0] qtype, logic [31:0] srv, logic v6);
      send(1'b0, key, t, port, qtype, srv, v6, 16'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_response(logic [47:0] key, logic [63:0] t, logic [15:0] rlen,
                                logic [7:0] flags, logic [7:0] rcode);
      send(1'b1, key, t, 16'($urandom), 16'($urandom), 32'($urandom), 1'($urandom),
           rlen, flags, rcode);
   endtask

   task automatic drain_and_configure(logic [63:0] threshold);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= threshold;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_traffic(int count);
      logic [47:0] key;
      logic [15:0] port;
      logic [15:0] rlen;
      logic [7:0] flags;
      for (int n = 0; n < count; n++) begin
         key = flow_pool[$urandom_range(7)];
         if ($urandom_range(99) < 5) key = 48'({$urandom, $urandom});
         if ($urandom_range(99) < 3) clock_ns = {$urandom, $urandom};
         else clock_ns += 64'($urandom_range(3000));
         if ($urandom_range(1)) begin
            port = ($urandom_range(99) < 10) ? 16'($urandom) : dtpm_pkg::QUERY_PORT;
            send_query(key, clock_ns, port, 16'($urandom), 32'($urandom),
                       1'($urandom_range(1)));
         end else begin
            rlen = ($urandom_range(99) < 10) ? 16'($urandom_range(11))
                                             : 16'($urandom_range(65535, 12));
            flags = 8'($urandom);
            if ($urandom_range(99) < 70) flags[dtpm_pkg::TC_BIT] = 1'b0;
            send_response(key, clock_ns, rlen, flags, 8'($urandom));
         end
      end
   endtask

   initial begin
      foreach (flow_pool[i]) flow_pool[i] = {1'b0, 15'($urandom), $urandom};
      flow_pool[0] = '0;
      flow_pool[1] = 48'h7FFF_FFFF_FFFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (1100) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= '0;
      @(posedge clock);
      csr_write_enable <= 1'b0;

      send_query(48'h0, 64'h0, dtpm_pkg::QUERY_PORT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      send_response(48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd12, 8'h00, 8'h00);
      send_query(48'h5, 64'd10, 16'd52, 16'd1, 32'h1, 1'b0);
      send_response(48'h5, 64'd20, 16'd100, 8'h00, 8'h03);
      send_query(48'hFFFF_FFFF_FFFF, 64'd100, dtpm_pkg::QUERY_PORT, 16'd28, 32'hDEAD_BEEF,
                 1'b1);
      send_query(48'hFFFF_FFFF_FFFF, 64'd150, dtpm_pkg::QUERY_PORT, 16'd1, 32'h0A00_0001,
                 1'b0);
      send_response(48'hFFFF_FFFF_FFFF, 64'd200, 16'd40, 8'h02, 8'h03);
      send_query(48'h1, 64'd300, dtpm_pkg::QUERY_PORT, 16'd1, 32'h0808_0808, 1'b0);
      send_response(48'h1, 64'd301, 16'd11, 8'h00, 8'h03);
      send_response(48'h1, 64'd302, 16'd12, 8'h00, 8'hF3);
      send_query(48'h2, 64'd400, dtpm_pkg::QUERY_PORT, 16'd2, 32'h1, 1'b0);
      send_response(48'h2, 64'd405, 16'hFFFF, 8'hFD, 8'h02);
      send_query(48'h3, 64'd500, dtpm_pkg::QUERY_PORT, 16'd3, 32'h2, 1'b1);
      send_response(48'h3, 64'd400, 16'd512, 8'h00, 8'h05);
      send_response(48'h3, 64'd600, 16'd512, 8'h00, 8'h05);
      send_query(48'h4, 64'd700, dtpm_pkg::QUERY_PORT, 16'd4, 32'h3, 1'b0);
      send_response(48'h4, 64'd700, 16'd64, 8'hFF, 8'hFF);
      send_query(48'h6, 64'd800, dtpm_pkg::QUERY_PORT, 16'd5, 32'h4, 1'b0);
      send_response(48'h6, 64'd800, 16'd64, 8'h00, 8'h00);
      send_query(48'h7, 64'd900, dtpm_pkg::QUERY_PORT, 16'd6, 32'h5, 1'b0);
      send_response(48'h7, 64'd901, 16'd64, 8'h00, 8'h01);

      drain_and_configure(64'hFFFF_FFFF_FFFF_FFFF);
      tx_idle_pct = 17;
      rx_idle_pct = 88;
      random_traffic(120);
      for (int n = 0; n < 260; n++)
         send_query(flow_pool[2], clock_ns + 64'(n), dtpm_pkg::QUERY_PORT, 16'($urandom),
                    32'($urandom), 1'($urandom_range(1)));
      send_response(flow_pool[2], clock_ns + 64'd9999, 16'd12, 8'h00, 8'h02);

      drain_and_configure(64'd5000);
      tx_idle_pct = 88;
      rx_idle_pct = 17;
      random_traffic(100);
      for (int n = 0; n < dtpm_pkg::TABLE_ENTRIES + 2; n++)
         send_query({1'b1, 47'(n)}, clock_ns, dtpm_pkg::QUERY_PORT, 16'($urandom),
                    32'($urandom), 1'($urandom_range(1)));
      foreach (flow_pool[i])
         send_response(flow_pool[i], clock_ns + 64'd6000, 16'd12, 8'h00, 8'h00);
      for (int n = 0; n < 64; n++)
         send_response({1'b1, 47'(n)}, clock_ns + 64'($urandom_range(10000)), 16'd12,
                       8'h00, 8'($urandom));

      drain_and_configure({$urandom, $urandom});
      drain_and_configure(64'd0);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_traffic(100);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_events == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
